// ===== hw/rtl/code11_barcode_module_encoder_top_macros.svh =====
// Assertion macros used by the encoder checker
`ifndef CODE11_BARCODE_MODULE_ENCODER_TOP_MACROS_SVH
`define CODE11_BARCODE_MODULE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define C11ENC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("c11enc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define C11ENC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("c11enc assertion failed");

`endif

// ===== hw/rtl/c11enc_pkg.sv =====
// Types, constants and symbol tables for the Code 11 module encoder
package c11enc_pkg;

    localparam int MAX_CHARS  = 255;
    localparam int CHAR_CNT_W = $clog2(MAX_CHARS + 1);

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    localparam logic [3:0]  MARKER_SLOT = 4'd8;
    localparam logic [11:0] COUNT_MAX   = 12'hFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
    } in_word_t;

    typedef struct packed {
        logic        module_res;
        logic        error;
        logic        last;
        logic [11:0] total_modules;
    } out_word_t;

    // Work handed from the front to the back: bits left-aligned, gap included but for the stop
    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] len;
        logic       clear;
        logic       stop;
        logic       err_stop;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
    } lookup_t;

    function automatic lookup_t symbol_lookup(input logic [7:0] code);
        lookup_t r;
        r.hit  = 1'b1;
        r.slot = 4'd0;
        case (code)
            8'h31:   r.slot = 4'd0;
            8'h32:   r.slot = 4'd1;
            8'h33:   r.slot = 4'd2;
            8'h34:   r.slot = 4'd3;
            8'h35:   r.slot = 4'd4;
            8'h36:   r.slot = 4'd5;
            8'h37:   r.slot = 4'd6;
            8'h38:   r.slot = 4'd7;
            8'h2A:   r.slot = 4'd8;
            8'h39:   r.slot = 4'd9;
            8'h30:   r.slot = 4'd10;
            8'h2D:   r.slot = 4'd11;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] bar_pattern(input logic [3:0] slot);
        logic [6:0] p;
        case (slot)
            4'd0:    p = 7'h6B;
            4'd1:    p = 7'h4B;
            4'd2:    p = 7'h65;
            4'd3:    p = 7'h5B;
            4'd4:    p = 7'h6D;
            4'd5:    p = 7'h4D;
            4'd6:    p = 7'h53;
            4'd7:    p = 7'h69;
            4'd8:    p = 7'h59;
            4'd9:    p = 7'h35;
            4'd10:   p = 7'h2B;
            4'd11:   p = 7'h2D;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/code11_barcode_module_encoder_top.sv =====
// Top level of the Code 11 module encoder
//
//   port group   direction   payload      handshake
//   s_*          in          in_word_t    s_valid / s_ready
//   m_*          out         out_word_t   m_valid / m_ready
//
// One module word leaves per cycle unless m_ready holds it back; a character gives 7 or 8 words, the start
// item 8, the stop item 7 (1 after an error), set by the single serialiser.
// Items that give no words are taken at the input and send nothing to the output.
// Reset is synchronous and clears the barcode state, the queue and the output.
// A two-command queue lets the input run ahead while the output is stalled.
module code11_barcode_module_encoder_top import c11enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_cmd, q_head;

    c11enc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    c11enc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    c11enc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hw/rtl/c11enc_front.sv =====
// Front end: accepts input words, tracks per-barcode state, issues commands
module c11enc_front import c11enc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic                  error_seen_reg, error_seen_next;
    logic [CHAR_CNT_W-1:0] char_cnt_reg, char_cnt_next;
    logic                  accept;
    lookup_t               lk;
    logic [6:0]            pat;
    logic [6:0]            marker;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign lk      = symbol_lookup(s_data.char_code);
    assign pat     = bar_pattern(lk.slot);
    assign marker  = bar_pattern(MARKER_SLOT);

    always_comb begin
        error_seen_next = error_seen_reg;
        char_cnt_next   = char_cnt_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        if (accept) begin
            case (s_data.kind)
                KIND_START: begin
                    error_seen_next = 1'b0;
                    char_cnt_next   = '0;
                    q_push          = 1'b1;
                    q_cmd.bits      = {marker, 1'b0};
                    q_cmd.len       = 4'd8;
                    q_cmd.clear     = 1'b1;
                end
                KIND_CHAR: begin
                    if (!error_seen_reg) begin
                        if (!lk.hit) begin
                            error_seen_next = 1'b1;
                        end else if (char_cnt_reg < CHAR_CNT_W'(MAX_CHARS)) begin
                            char_cnt_next = char_cnt_reg + CHAR_CNT_W'(1);
                            q_push        = 1'b1;
                            // slots past the marker have six-module patterns
                            if (lk.slot > MARKER_SLOT) begin
                                q_cmd.bits = {pat[5:0], 2'b00};
                                q_cmd.len  = 4'd7;
                            end else begin
                                q_cmd.bits = {pat, 1'b0};
                                q_cmd.len  = 4'd8;
                            end
                        end
                    end
                end
                KIND_STOP: begin
                    q_push = 1'b1;
                    if (error_seen_reg) begin
                        q_cmd.len      = 4'd1;
                        q_cmd.err_stop = 1'b1;
                    end else begin
                        q_cmd.bits = {marker, 1'b0};
                        q_cmd.len  = 4'd7;
                        q_cmd.stop = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_seen_reg <= 1'b0;
            char_cnt_reg   <= '0;
        end else begin
            error_seen_reg <= error_seen_next;
            char_cnt_reg   <= char_cnt_next;
        end
    end

endmodule

// ===== hw/rtl/c11enc_queue.sv =====
// Two-entry command queue between front and back
module c11enc_queue import c11enc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/c11enc_back.sv =====
// Back end: serialises commands into module words and keeps the module count
module c11enc_back import c11enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    input  cmd_t      q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic [7:0]  bits_reg, bits_next;
    logic [3:0]  len_reg, len_next;
    logic        stop_reg, stop_next;
    logic        err_reg, err_next;
    logic [11:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;
    logic        advance, emit, finishing, final_bit;
    logic [11:0] count_inc;

    assign advance   = !out_valid_reg || m_ready;
    assign emit      = advance && (len_reg != 4'd0);
    assign final_bit = (len_reg == 4'd1);
    assign finishing = (len_reg == 4'd0) || (emit && final_bit);
    assign q_pop     = finishing && !q_empty;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 12'd1;

    always_comb begin
        bits_next      = bits_reg;
        len_next       = len_reg;
        stop_next      = stop_reg;
        err_next       = err_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        if (emit) begin
            out_next.module_res    = bits_reg[7];
            out_next.error         = err_reg;
            out_next.last          = err_reg || (stop_reg && final_bit);
            out_next.total_modules = (!err_reg && stop_reg && final_bit) ? count_inc : 12'd0;
            // the error word after a failed barcode is not counted
            count_next = err_reg ? count_reg : count_inc;
            bits_next  = {bits_reg[6:0], 1'b0};
            len_next   = len_reg - 4'd1;
        end
        if (q_pop) begin
            bits_next = q_head.bits;
            len_next  = q_head.len;
            stop_next = q_head.stop;
            err_next  = q_head.err_stop;
            if (q_head.clear) begin
                count_next = 12'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        stop_reg <= stop_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= 4'd0;
            count_reg     <= 12'd0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hw/rtl/c11enc_checker.sv =====
// Port-level checks on the encoder output, bound to the top level
`include "code11_barcode_module_encoder_top_macros.svh"

module c11enc_checker import c11enc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    logic out_stall;
    logic err_word;
    logic total_zero;
    logic err_clean;

    assign out_stall  = m_valid && !m_ready;
    assign err_word   = m_valid && m_data.error;
    assign total_zero = (m_data.total_modules == 12'd0);
    assign err_clean  = !m_data.module_res && total_zero;

    // hold a stalled word
    `C11ENC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))

    `C11ENC_ASSERT_NOW(a_err_is_last, aclk, aresetn, err_word, m_data.last)

    `C11ENC_ASSERT_NOW(a_err_word_zero, aclk, aresetn, err_word, err_clean)

    // the total only shows on the final word
    `C11ENC_ASSERT_NOW(a_total_only_last, aclk, aresetn, m_valid && !m_data.last, total_zero)

endmodule

bind code11_barcode_module_encoder_top c11enc_checker u_c11enc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
